/* sv/sitdt_pkg.sv */
package sitdt_pkg;

  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned NUM_DIGITS      = 10;
  localparam int unsigned BCD_W           = 4 * NUM_DIGITS;
  localparam int unsigned SHIFT_W         = BCD_W + VALUE_W;
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned CONV_STAGES     = VALUE_W / STEPS_PER_STAGE;
  localparam int unsigned IDX_W           = 4;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] MINUS_SIGN = 8'h2D;

  typedef logic [SHIFT_W-1:0] shift_word_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGITS
  } em_state_t;

  function automatic shift_word_t dabble_step(input shift_word_t s);
    shift_word_t t;
    logic [3:0]  nib;
    t = s;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      nib = t[VALUE_W + 4*d +: 4];
      if (nib >= 4'd5) begin
        t[VALUE_W + 4*d +: 4] = nib + 4'd3;
      end
    end
    return {t[SHIFT_W-2:0], 1'b0};
  endfunction

  function automatic shift_word_t dabble_stage(input shift_word_t s);
    shift_word_t t;
    t = s;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      t = dabble_step(t);
    end
    return t;
  endfunction

  function automatic logic [IDX_W-1:0] find_msd(input logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        idx = IDX_W'(d);
      end
    end
    return idx;
  endfunction

endpackage

/* sv/signed_int_to_decimal_text.sv */
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+------------------------------
// input    | in_value                                | taken when start && !busy
// result   | out_text_char, out_last_char            | one cycle each, out_valid
//
// An item passes an input register and eight stages of four shift-add-3 steps
// each before the character emitter takes it. It then gives one character
// per cycle, 1 to 11 in all; the single character port sets the sustained rate,
// as the emitter takes a new item only when idle or on the current last character.
// Reset is synchronous and active low and empties every stage.
// Stages hold their items while the character emitter is busy; busy is high
// when the input register cannot move on. The receiver cannot stall.
module signed_int_to_decimal_text (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [sitdt_pkg::VALUE_W-1:0] in_value,
  output logic                           out_valid,
  output logic [7:0]                     out_text_char,
  output logic                           out_last_char
);
  import sitdt_pkg::*;

  localparam int unsigned NSTG = CONV_STAGES + 1;

  logic                     valid_r [NSTG];
  logic                     neg_r   [NSTG];
  shift_word_t              sh_r    [NSTG];
  logic                     ready   [NSTG+1];

  em_state_t                state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [BCD_W-1:0]         digits_r;
  logic                     em_neg_r;
  logic                     take;
  logic [VALUE_W-1:0]       mag;
  logic [3:0]               cur_digit;

  assign mag  = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
  assign take = valid_r[NSTG-1] &&
                ((state_r == EM_IDLE) || ((state_r == EM_DIGITS) && (idx_r == '0)));

  assign ready[NSTG] = take;
  for (genvar k = 0; k < NSTG; k++) begin : g_ready
    assign ready[k] = !valid_r[k] || ready[k+1];
  end
  assign busy = !ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (ready[0]) begin
      valid_r[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0] && start) begin
      neg_r[0] <= in_value[VALUE_W-1];
      sh_r[0]  <= {{BCD_W{1'b0}}, mag};
    end
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_r[k] <= valid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ready[k] && valid_r[k-1]) begin
        neg_r[k] <= neg_r[k-1];
        sh_r[k]  <= dabble_stage(sh_r[k-1]);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (take) begin
          state_nxt = neg_r[NSTG-1] ? EM_SIGN : EM_DIGITS;
        end
      end
      EM_SIGN: begin
        state_nxt = EM_DIGITS;
      end
      EM_DIGITS: begin
        if (idx_r == '0) begin
          if (take) begin
            state_nxt = neg_r[NSTG-1] ? EM_SIGN : EM_DIGITS;
          end else begin
            state_nxt = EM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = find_msd(sh_r[NSTG-1][SHIFT_W-1:VALUE_W]);
    end else if ((state_r == EM_DIGITS) && (idx_r != '0)) begin
      idx_nxt = idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      digits_r <= sh_r[NSTG-1][SHIFT_W-1:VALUE_W];
      em_neg_r <= neg_r[NSTG-1];
    end
  end

  assign cur_digit = digits_r[4*idx_r +: 4];

  always_comb begin
    out_valid     = 1'b0;
    out_text_char = DIGIT_ZERO;
    out_last_char = 1'b0;
    case (state_r)
      EM_IDLE: begin
        out_valid = 1'b0;
      end
      EM_SIGN: begin
        out_valid     = 1'b1;
        out_text_char = MINUS_SIGN;
      end
      EM_DIGITS: begin
        out_valid     = 1'b1;
        out_text_char = DIGIT_ZERO + {4'd0, cur_digit};
        out_last_char = (idx_r == '0);
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_char |-> out_valid)
    else $error("last character flagged without a valid character");

  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EM_SIGN) |=> (state_r == EM_DIGITS))
    else $error("sign not followed by a digit");

  a_sign_from_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EM_SIGN) |-> em_neg_r)
    else $error("sign emitted for a non-negative item");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> valid_r[0])
    else $error("accepted item did not enter the input stage");

endmodule
